### hdl/rws_pkg.sv
// Shared types and constants for the roulette wheel selector.
package rws_pkg;

   // Fixed field widths of the request and response payloads
   localparam int FIT_W  = 16;
   localparam int RND_W  = 16;
   localparam int PIDX_W = 6;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SELECT = 2'd2,
      OP_NONE   = 2'd3
   } rws_op_type;

   typedef struct packed {
      rws_op_type         opcode;
      logic [FIT_W-1:0]   fitness_value;
      logic [RND_W-1:0]   random_fraction;
   } rws_req_type;

   typedef struct packed {
      logic [PIDX_W-1:0]  parent_index;
      logic               found;
   } rws_rsp_type;

   // Scan token control bits handed from cell to cell
   typedef struct packed {
      logic valid;
      logic found;
   } rws_tok_type;

   // Table write broadcast to all cells
   typedef struct packed {
      logic               wr_en;
      logic [FIT_W-1:0]   wr_data;
   } rws_wr_type;

endpackage

### hdl/rws_cell.sv
// One table cell: holds one fitness entry and advances the scan token by one step.
module rws_cell
   import rws_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rws_wr_type                            wr,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]      count,
   input  logic [FIT_W+$clog2(MAX_ENTRIES)-1:0]  slice,
   input  rws_tok_type                           tok_in,
   input  logic [FIT_W+$clog2(MAX_ENTRIES)-1:0]  cum_in,
   input  logic [$clog2(MAX_ENTRIES)-1:0]        idx_in,
   output rws_tok_type                           tok_out,
   output logic [FIT_W+$clog2(MAX_ENTRIES)-1:0]  cum_out,
   output logic [$clog2(MAX_ENTRIES)-1:0]        idx_out
);

   localparam int CNT_W = $clog2(MAX_ENTRIES+1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int TOT_W = FIT_W + IDX_W;

   logic [FIT_W-1:0]  fit_ff;
   rws_tok_type       tok_ff;
   logic [TOT_W-1:0]  cum_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic              occupied;
   logic              take;
   logic              hit;
   logic [TOT_W-1:0]  sum;

   // entry storage, written when this cell is the next free slot
   always_ff @(posedge clock) begin
      if (wr.wr_en && count == CNT_W'(CELL_INDEX)) begin
         fit_ff <= wr.wr_data;
      end
   end

   // accumulate and compare while the token has not found a parent yet
   assign occupied = count > CNT_W'(CELL_INDEX);
   assign take     = tok_in.valid && !tok_in.found && occupied;
   assign sum      = cum_in + {{IDX_W{1'b0}}, fit_ff};
   assign hit      = take && (sum >= slice);

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff.valid <= tok_in.valid;
         tok_ff.found <= tok_in.found | hit;
      end
   end

   always_ff @(posedge clock) begin
      cum_ff <= take ? sum : cum_in;
      idx_ff <= hit ? IDX_W'(CELL_INDEX) : idx_in;
   end

   assign tok_out = tok_ff;
   assign cum_out = cum_ff;
   assign idx_out = idx_ff;

endmodule

### hdl/rws_ctrl.sv
// Request decode, running total, shift-add slice multiplier and response register.
module rws_ctrl
   import rws_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rws_req_type                           req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rws_rsp_type                           rsp_data,
   output rws_wr_type                            wr,
   output logic [$clog2(MAX_ENTRIES+1)-1:0]      count,
   output logic [FIT_W+$clog2(MAX_ENTRIES)-1:0]  slice,
   output logic                                  start,
   input  rws_tok_type                           tail_tok,
   input  logic [$clog2(MAX_ENTRIES)-1:0]        tail_idx
);

   localparam int CNT_W = $clog2(MAX_ENTRIES+1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int TOT_W = FIT_W + IDX_W;
   localparam int ACC_W = RND_W + TOT_W;
   localparam int BIT_W = $clog2(RND_W);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MULT = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_HOLD = 4'b1000
   } rws_state_type;

   rws_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic                start_ff, start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rws_rsp_type         rsp_ff, rsp_in;
   rws_rsp_type         res_ff, res_in;

   logic                req_fire;
   logic                slot_free;
   logic [IDX_W+PIDX_W-1:0] idx_ext;

   assign req_fire  = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign idx_ext   = {{PIDX_W{1'b0}}, tail_idx};

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      rnd_in       = rnd_ff;
      bit_in       = bit_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      wr.wr_en     = 1'b0;
      wr.wr_data   = req_data.fitness_value;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                        wr.wr_en = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        total_in = total_ff + {{IDX_W{1'b0}}, req_data.fitness_value};
                     end
                  end
                  OP_SELECT: begin
                     acc_in   = '0;
                     rnd_in   = req_data.random_fraction;
                     bit_in   = BIT_W'(RND_W - 1);
                     state_in = ST_MULT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // one fraction bit per cycle, most significant first
         ST_MULT: begin
            acc_in = {acc_ff[ACC_W-2:0], 1'b0}
                   + (rnd_ff[RND_W-1] ? {{RND_W{1'b0}}, total_ff} : '0);
            rnd_in = {rnd_ff[RND_W-2:0], 1'b0};
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               start_in = 1'b1;
               state_in = ST_SCAN;
            end
         end
         // wait for the token to leave the last cell
         ST_SCAN: begin
            if (tail_tok.valid) begin
               res_in.found        = tail_tok.found;
               res_in.parent_index = tail_tok.found ? idx_ext[PIDX_W-1:0] : '0;
               state_in            = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rnd_ff <= rnd_in;
      bit_ff <= bit_in;
      rsp_ff <= rsp_in;
      res_ff <= res_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign count     = count_ff;
   assign slice     = acc_ff[RND_W +: TOT_W];
   assign start     = start_ff;

endmodule

### hdl/roulette_wheel_select.sv
// Top level of the roulette wheel selector: controller plus a chain of table cells.
//
// Fitness-proportionate selection over a table of up to MAX_ENTRIES unsigned 16-bit
// fitness values. Clear and append requests are taken in the idle state; an append to
// a full table is dropped. A select request forms slice = (random_fraction * total) >> 16
// in a shift-add multiplier, one fraction bit per cycle, then sends a scan token down
// the chain of cells, one cell per cycle, each cell adding its entry to the running sum
// and marking the first index whose sum reaches the slice. The token passes every cell
// whatever the fill level, and the result waits in the controller until the response
// register is free; requests are held off while a select is in progress. The response
// register lets the next request in while a result is still waiting to be taken. An
// empty table answers found = 0, parent_index = 0.
module roulette_wheel_select
   import rws_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rws_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rws_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES+1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int TOT_W = FIT_W + IDX_W;

   rws_wr_type        wr;
   logic [CNT_W-1:0]  count;
   logic [TOT_W-1:0]  slice;
   logic              start;

   rws_tok_type       tok [0:MAX_ENTRIES];
   logic [TOT_W-1:0]  cum [0:MAX_ENTRIES];
   logic [IDX_W-1:0]  idx [0:MAX_ENTRIES];

   rws_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .wr        (wr),
      .count     (count),
      .slice     (slice),
      .start     (start),
      .tail_tok  (tok[MAX_ENTRIES]),
      .tail_idx  (idx[MAX_ENTRIES])
   );

   // token enters at the head of the chain with an empty sum
   assign tok[0].valid = start;
   assign tok[0].found = 1'b0;
   assign cum[0]       = '0;
   assign idx[0]       = '0;

   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      rws_cell #(
         .MAX_ENTRIES (MAX_ENTRIES),
         .CELL_INDEX  (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr      (wr),
         .count   (count),
         .slice   (slice),
         .tok_in  (tok[k]),
         .cum_in  (cum[k]),
         .idx_in  (idx[k]),
         .tok_out (tok[k+1]),
         .cum_out (cum[k+1]),
         .idx_out (idx[k+1])
      );
   end

endmodule

### hdl/rws_checker.sv
// Port-level checks for the roulette wheel selector, bound to the top level.
module rws_checker
   import rws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  rws_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rws_rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // no response right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // a select request keeps the block busy
   a_sel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OP_SELECT |=> req_stall)
      else $error("request taken during select");

   // requests other than select never produce a response
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall && req_data.opcode != OP_SELECT
      |=> !rsp_valid)
      else $error("response from non-select request");

endmodule

bind roulette_wheel_select rws_checker u_rws_checker (.*);

### verif/roulette_wheel_select_test.sv
// Self-checking testbench for the roulette wheel selector: scripted and random requests.
module roulette_wheel_select_test;
   import rws_pkg::*;

   localparam int MAX_SLOTS    = 64;
   localparam int ITEM_TARGET  = 1250;
   localparam int DRAIN_CYCLES = 120;       // extra wait after the last expected response
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SCRIPT_LEN   = 18;

   // One scripted request; answer is used only where typed is set
   typedef struct packed {
      rws_req_type req;
      logic        typed;
      rws_rsp_type answer;
   } script_row_type;

   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{'{OP_SELECT, 16'h0000, 16'h0000}, 1'b1, '{6'd0, 1'b0}},   // empty after reset
      '{'{OP_NONE,   16'hFFFF, 16'hFFFF}, 1'b0, '{6'd0, 1'b0}},   // unused opcode
      '{'{OP_SELECT, 16'hFFFF, 16'hFFFF}, 1'b1, '{6'd0, 1'b0}},   // still empty
      '{'{OP_APPEND, 16'h0000, 16'hFFFF}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_APPEND, 16'h0000, 16'h0000}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_SELECT, 16'h0000, 16'hFFFF}, 1'b1, '{6'd0, 1'b1}},   // all fitness zero
      '{'{OP_CLEAR,  16'hFFFF, 16'hFFFF}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_APPEND, 16'hFFFF, 16'h0000}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_APPEND, 16'h0001, 16'h0000}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_APPEND, 16'hFFFF, 16'h0000}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_SELECT, 16'h0000, 16'h0000}, 1'b1, '{6'd0, 1'b1}},   // zero fraction
      '{'{OP_SELECT, 16'h0000, 16'hFFFF}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_SELECT, 16'h0000, 16'h8000}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_SELECT, 16'h0000, 16'h0001}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_CLEAR,  16'h0000, 16'h0000}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_SELECT, 16'h0000, 16'hFFFF}, 1'b1, '{6'd0, 1'b0}},   // empty after clear
      '{'{OP_APPEND, 16'h1234, 16'h5678}, 1'b0, '{6'd0, 1'b0}},
      '{'{OP_SELECT, 16'h0000, 16'hFFFF}, 1'b1, '{6'd0, 1'b1}}    // single entry
   };

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rws_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rws_rsp_type rsp_data;

   // Local copy of the selector state
   logic [FIT_W-1:0] wheel_slots [MAX_SLOTS];
   int               slot_count  = 0;
   logic [21:0]      wheel_total = '0;

   rws_rsp_type pending_picks [$];
   int          fail_count     = 0;
   int          effective_reqs = 0;
   int          cycle_count    = 0;
   logic        sender_calm    = 1'b0;
   logic        receiver_calm  = 1'b0;

   roulette_wheel_select #(.MAX_ENTRIES(MAX_SLOTS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Update the state copy for one accepted request and work out its pick
   task automatic apply_request(input rws_req_type req, output logic answers,
                                output rws_rsp_type pick, output logic counted);
      logic [37:0] product;
      logic [21:0] slice;
      logic [22:0] running;
      answers = 1'b0;
      pick    = '0;
      counted = 1'b1;
      case (req.opcode)
         OP_CLEAR: begin
            slot_count  = 0;
            wheel_total = '0;
         end
         OP_APPEND: begin
            // a full table drops the append
            if (slot_count < MAX_SLOTS) begin
               wheel_slots[slot_count] = req.fitness_value;
               slot_count  = slot_count + 1;
               wheel_total = wheel_total + 22'(req.fitness_value);
            end else begin
               counted = 1'b0;
            end
         end
         OP_SELECT: begin
            answers = 1'b1;
            product = 38'(req.random_fraction) * 38'(wheel_total);
            slice   = product[37:16];
            running = '0;
            for (int i = 0; i < slot_count; i++) begin
               running = running + 23'(wheel_slots[i]);
               if (!pick.found && running >= 23'(slice)) begin
                  pick.parent_index = PIDX_W'(i);
                  pick.found        = 1'b1;
               end
            end
         end
         default: counted = 1'b0;
      endcase
   endtask

   // Wait a random gap, present the request and hold it until taken
   task automatic send_request(input rws_req_type req, input logic typed,
                               input rws_rsp_type answer);
      int          gap;
      logic        answers;
      logic        counted;
      rws_rsp_type pick;
      gap = sender_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (!(req_valid && !req_stall));
      apply_request(req, answers, pick, counted);
      if (answers)
         pending_picks.insert(pending_picks.size(), typed ? answer : pick);
      if (counted)
         effective_reqs++;
   endtask

   function automatic rws_req_type random_item(input rws_op_type op);
      rws_req_type req;
      req.opcode          = op;
      req.fitness_value   = FIT_W'($urandom);
      req.random_fraction = RND_W'($urandom);
      return req;
   endfunction

   // Stray request now and then: mostly the unused opcode, sometimes anything
   task automatic send_noise();
      if ($urandom_range(0, 19) == 0)
         send_request(random_item(OP_NONE), 1'b0, '0);
      else if ($urandom_range(0, 39) == 0)
         send_request(random_item(rws_op_type'($urandom_range(0, 3))), 1'b0, '0);
   endtask

   // One round: optional clear, fill the table, then a burst of selects
   task automatic run_round();
      int          fill;
      int          flavor;
      int          picks;
      rws_req_type req;
      sender_calm = ($urandom_range(0, 3) == 0);
      flavor      = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0:       fill = $urandom_range(0, 3);
         1:       fill = $urandom_range(4, 20);
         2:       fill = $urandom_range(21, 59);
         default: fill = $urandom_range(60, 72);
      endcase
      if ($urandom_range(0, 3) != 0)
         send_request(random_item(OP_CLEAR), 1'b0, '0);
      for (int k = 0; k < fill; k++) begin
         req = random_item(OP_APPEND);
         case (flavor)
            0: ;                                          // full range
            1: req.fitness_value = FIT_W'($urandom_range(0, 15));
            2: if ($urandom_range(0, 7) != 0) req.fitness_value = '0;
            default: req.fitness_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         endcase
         send_noise();
         send_request(req, 1'b0, '0);
      end
      picks = $urandom_range(2, 12);
      for (int k = 0; k < picks; k++) begin
         req = random_item(OP_SELECT);
         case ($urandom_range(0, 7))
            0: req.random_fraction = 16'h0000;
            1: req.random_fraction = 16'hFFFF;
            default: ;
         endcase
         send_noise();
         send_request(req, 1'b0, '0);
      end
   endtask

   // Compare one taken response with the oldest expected pick
   task automatic check_pick(input rws_rsp_type got);
      rws_rsp_type want;
      if (pending_picks.size() == 0) begin
         $display("%0t: response with none expected: index %0d found %0b",
                  $time, got.parent_index, got.found);
         fail_count++;
      end else begin
         want = pending_picks.pop_front();
         if (got.parent_index !== want.parent_index) begin
            $display("%0t: parent_index expected %0d actual %0d",
                     $time, want.parent_index, got.parent_index);
            fail_count++;
         end
         if (got.found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
            fail_count++;
         end
      end
   endtask

   // Response side: hold each waiting result off for a random count of cycles
   initial begin
      int stall_len;
      int taken;
      taken = 0;
      wait (!reset);
      forever begin
         stall_len = receiver_calm ? 0 : $urandom_range(0, 10);
         if (stall_len == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall_len - 1) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         check_pick(rsp_data);
         taken++;
         if (taken % 25 == 0)
            receiver_calm = ($urandom_range(0, 2) == 0);
      end
   end

   // Reset, scripted requests, random rounds, then drain
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < SCRIPT_LEN; n++)
         send_request(SCRIPT[n].req, SCRIPT[n].typed, SCRIPT[n].answer);
      while (effective_reqs < ITEM_TARGET)
         run_round();
      req_valid <= 1'b0;
      while (pending_picks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
